// ----- hw/rtl/afl_pkg.sv -----
// types, operation codes and constants shared by the flag-setting alu
package afl_pkg;

    // operation codes
    localparam logic [4:0] ACT_ADD = 5'd0;
    localparam logic [4:0] ACT_ADC = 5'd1;
    localparam logic [4:0] ACT_SUB = 5'd2;
    localparam logic [4:0] ACT_SBC = 5'd3;
    localparam logic [4:0] ACT_CMP = 5'd4;
    localparam logic [4:0] ACT_AND = 5'd5;
    localparam logic [4:0] ACT_OR  = 5'd6;
    localparam logic [4:0] ACT_XOR = 5'd7;
    localparam logic [4:0] ACT_NOT = 5'd8;
    localparam logic [4:0] ACT_INC = 5'd9;
    localparam logic [4:0] ACT_DEC = 5'd10;
    localparam logic [4:0] ACT_SLA = 5'd11;
    localparam logic [4:0] ACT_SRA = 5'd12;
    localparam logic [4:0] ACT_SRL = 5'd13;
    localparam logic [4:0] ACT_RL  = 5'd14;
    localparam logic [4:0] ACT_RLC = 5'd15;
    localparam logic [4:0] ACT_RR  = 5'd16;
    localparam logic [4:0] ACT_RRC = 5'd17;
    localparam logic [4:0] ACT_BIT = 5'd18;
    localparam logic [4:0] ACT_TOG = 5'd19;
    localparam logic [4:0] ACT_SET = 5'd20;
    localparam logic [4:0] ACT_RES = 5'd21;
    localparam logic [4:0] ACT_DAA = 5'd22;
    localparam logic [4:0] ACT_SCF = 5'd23;
    localparam logic [4:0] ACT_CCF = 5'd24;

    // width selector codes, anything else is a byte
    localparam logic [1:0] WS_32 = 2'd0;
    localparam logic [1:0] WS_16 = 2'd1;

    // operand masks and half carry masks per width
    localparam logic [31:0] MASK_32      = 32'hFFFF_FFFF;
    localparam logic [31:0] MASK_16      = 32'h0000_FFFF;
    localparam logic [31:0] MASK_8       = 32'h0000_00FF;
    localparam logic [31:0] HALF_MASK_32 = 32'h0FFF_FFFF;
    localparam logic [31:0] HALF_MASK_16 = 32'h0000_0FFF;
    localparam logic [31:0] HALF_MASK_8  = 32'h0000_000F;
    localparam logic [4:0]  TOP_32       = 5'd31;
    localparam logic [4:0]  TOP_16       = 5'd15;
    localparam logic [4:0]  TOP_8        = 5'd7;

    // decimal adjust constants
    localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
    localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;
    localparam logic [3:0] DAA_DIGIT_MAX = 4'h9;

    // flag register, zero flag in bit 0
    typedef struct packed {
        logic sign;
        logic parity;
        logic carry;
        logic half_carry;
        logic subtract;
        logic zero;
    } flags_t;

    typedef struct packed {
        logic [4:0]  action;
        logic [31:0] left_operand;
        logic [31:0] right_operand;
        logic [1:0]  width_select;
        logic [7:0]  bit_index;
    } item_t;

    typedef struct packed {
        logic [31:0] result;
        flags_t      flags;
        logic        bad_bit_index;
    } result_t;

endpackage

// ----- hw/rtl/afl_if.sv -----
// valid/ready channel interfaces for input and result items
interface afl_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  action;
    logic [31:0] left_operand;
    logic [31:0] right_operand;
    logic [1:0]  width_select;
    logic [7:0]  bit_index;

    modport source (output valid, action, left_operand, right_operand, width_select,
                    bit_index, input ready);
    modport sink (input valid, action, left_operand, right_operand, width_select,
                  bit_index, output ready);
endinterface

interface afl_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result;
    logic        zero_flag;
    logic        subtract_flag;
    logic        half_carry_flag;
    logic        carry_flag;
    logic        parity_flag;
    logic        sign_flag;
    logic        bad_bit_index;

    modport source (output valid, result, zero_flag, subtract_flag, half_carry_flag,
                    carry_flag, parity_flag, sign_flag, bad_bit_index, input ready);
    modport sink (input valid, result, zero_flag, subtract_flag, half_carry_flag,
                  carry_flag, parity_flag, sign_flag, bad_bit_index, output ready);
endinterface

// ----- hw/rtl/afl_alu.sv -----
// single pass alu datapath: result, next flags and bit index error for one item
module afl_alu
(
    input  afl_pkg::item_t   item,
    input  afl_pkg::flags_t  flags_in,
    output afl_pkg::result_t res
);

    logic [31:0]     mask;
    logic [31:0]     half_mask;
    logic [31:0]     half_pos;
    logic [31:0]     top_onehot;
    logic [4:0]      top_idx;
    logic [31:0]     a;
    logic [31:0]     b;
    logic            cin;
    logic            c_add;
    logic            c_sub;
    logic [32:0]     sum_wide;
    logic [32:0]     diff_wide;
    logic            add_half;
    logic            sub_half;
    logic            add_carry;
    logic            borrow;
    logic            msb;
    logic            lsb;
    logic [31:0]     bit_onehot;
    logic            bit_bad;
    logic [7:0]      al;
    logic            daa_low;
    logic            daa_high;
    logic [7:0]      daa_adj;
    logic [7:0]      daa_val;
    logic [31:0]     r;
    logic            bad;
    afl_pkg::flags_t flags;

    // width decode
    always_comb
    begin
        case (item.width_select)
            afl_pkg::WS_32:
            begin
                mask      = afl_pkg::MASK_32;
                half_mask = afl_pkg::HALF_MASK_32;
                top_idx   = afl_pkg::TOP_32;
            end
            afl_pkg::WS_16:
            begin
                mask      = afl_pkg::MASK_16;
                half_mask = afl_pkg::HALF_MASK_16;
                top_idx   = afl_pkg::TOP_16;
            end
            default:
            begin
                mask      = afl_pkg::MASK_8;
                half_mask = afl_pkg::HALF_MASK_8;
                top_idx   = afl_pkg::TOP_8;
            end
        endcase
    end

    // shared operand terms
    always_comb
    begin
        top_onehot = mask ^ (mask >> 1);
        half_pos   = half_mask + 32'd1;
        a          = item.left_operand & mask;
        b          = item.right_operand & mask;
        cin        = flags_in.carry;
        c_add      = (item.action == afl_pkg::ACT_ADC) && cin;
        c_sub      = (item.action == afl_pkg::ACT_SBC) && cin;
        sum_wide   = {1'b0, a} + {1'b0, b} + {32'd0, c_add};
        diff_wide  = {1'b0, a} - {1'b0, b} - {32'd0, c_sub};
        // carry into the bit above the half mask
        add_half   = |((a ^ b ^ sum_wide[31:0]) & half_pos);
        sub_half   = |((a ^ b ^ diff_wide[31:0]) & half_pos);
        add_carry  = sum_wide > {1'b0, mask};
        borrow     = diff_wide[32];
        msb        = |(b & top_onehot);
        lsb        = b[0];
        bit_onehot = 32'd1 << item.bit_index[4:0];
        bit_bad    = item.bit_index > {3'd0, top_idx};
    end

    // decimal adjust on the low byte
    always_comb
    begin
        al       = item.left_operand[7:0];
        daa_low  = flags_in.half_carry || (al[3:0] > afl_pkg::DAA_DIGIT_MAX);
        daa_high = flags_in.carry || (al[7:4] > afl_pkg::DAA_DIGIT_MAX);
        daa_adj  = (daa_low ? afl_pkg::DAA_LOW_ADJ : 8'd0)
                 + (daa_high ? afl_pkg::DAA_HIGH_ADJ : 8'd0);
        daa_val  = flags_in.subtract ? (al - daa_adj) : (al + daa_adj);
    end

    // operation select and flag update
    always_comb
    begin
        flags = flags_in;
        r     = '0;
        bad   = 1'b0;
        case (item.action)
            afl_pkg::ACT_ADD, afl_pkg::ACT_ADC:
            begin
                r                = sum_wide[31:0] & mask;
                flags.subtract   = 1'b0;
                flags.sign       = 1'b0;
                flags.half_carry = add_half;
                flags.carry      = add_carry;
                flags.zero       = (r == '0);
                flags.parity     = ~^r;
            end
            afl_pkg::ACT_SUB, afl_pkg::ACT_SBC, afl_pkg::ACT_CMP:
            begin
                r                = diff_wide[31:0] & mask;
                flags.subtract   = 1'b1;
                flags.carry      = borrow;
                flags.sign       = borrow;
                flags.half_carry = sub_half;
                flags.zero       = (r == '0);
                // compare leaves parity and hands back the left operand
                if (item.action == afl_pkg::ACT_CMP)
                begin
                    r = a;
                end
                else
                begin
                    flags.parity = ~^r;
                end
            end
            afl_pkg::ACT_AND, afl_pkg::ACT_OR, afl_pkg::ACT_XOR:
            begin
                case (item.action)
                    afl_pkg::ACT_AND: r = a & b;
                    afl_pkg::ACT_OR:  r = a | b;
                    default:          r = a ^ b;
                endcase
                flags.subtract   = 1'b0;
                flags.half_carry = (item.action == afl_pkg::ACT_AND);
                flags.carry      = 1'b0;
                flags.sign       = 1'b0;
                flags.zero       = (r == '0);
                flags.parity     = ~^r;
            end
            afl_pkg::ACT_NOT:
            begin
                r                = ~b & mask;
                flags.subtract   = 1'b1;
                flags.half_carry = 1'b1;
            end
            afl_pkg::ACT_INC:
            begin
                r              = (b + 32'd1) & mask;
                flags.zero     = (r == '0);
                flags.parity   = ~^r;
                flags.subtract = 1'b0;
                if (item.width_select != afl_pkg::WS_32)
                begin
                    flags.half_carry = ((r & half_mask) == '0);
                end
            end
            afl_pkg::ACT_DEC:
            begin
                r              = (b - 32'd1) & mask;
                flags.zero     = (r == '0);
                flags.parity   = ~^r;
                flags.subtract = 1'b1;
                if (item.width_select != afl_pkg::WS_32)
                begin
                    flags.half_carry = ((r & half_mask) == half_mask);
                end
            end
            afl_pkg::ACT_SLA, afl_pkg::ACT_SRA, afl_pkg::ACT_SRL, afl_pkg::ACT_RL,
            afl_pkg::ACT_RLC, afl_pkg::ACT_RR, afl_pkg::ACT_RRC:
            begin
                case (item.action)
                    afl_pkg::ACT_SLA: r = b << 1;
                    afl_pkg::ACT_SRA: r = (b >> 1) | (msb ? top_onehot : '0);
                    afl_pkg::ACT_SRL: r = b >> 1;
                    afl_pkg::ACT_RL:  r = (b << 1) | {31'd0, cin};
                    afl_pkg::ACT_RLC: r = (b << 1) | {31'd0, msb};
                    afl_pkg::ACT_RR:  r = (b >> 1) | (cin ? top_onehot : '0);
                    default:          r = (b >> 1) | (lsb ? top_onehot : '0);
                endcase
                r                = r & mask;
                flags.subtract   = 1'b0;
                flags.half_carry = 1'b0;
                // left moves take the old top bit, right moves the old bit 0
                if ((item.action == afl_pkg::ACT_SLA) || (item.action == afl_pkg::ACT_RL)
                    || (item.action == afl_pkg::ACT_RLC))
                begin
                    flags.carry = msb;
                end
                else
                begin
                    flags.carry = lsb;
                end
                flags.zero = (r == '0);
                // plain rotates leave parity
                if ((item.action != afl_pkg::ACT_RLC) && (item.action != afl_pkg::ACT_RRC))
                begin
                    flags.parity = ~^r;
                end
            end
            afl_pkg::ACT_BIT, afl_pkg::ACT_TOG, afl_pkg::ACT_SET, afl_pkg::ACT_RES:
            begin
                if (bit_bad)
                begin
                    bad = 1'b1;
                    r   = (item.action == afl_pkg::ACT_BIT) ? a : b;
                end
                else
                begin
                    case (item.action)
                        afl_pkg::ACT_BIT:
                        begin
                            r                = a;
                            flags.zero       = ~|(b & bit_onehot);
                            flags.subtract   = 1'b0;
                            flags.half_carry = 1'b1;
                        end
                        afl_pkg::ACT_TOG: r = (b ^ bit_onehot) & mask;
                        afl_pkg::ACT_SET: r = (b | bit_onehot) & mask;
                        default:          r = b & ~bit_onehot & mask;
                    endcase
                end
            end
            afl_pkg::ACT_DAA:
            begin
                r                = {24'd0, daa_val};
                flags.carry      = daa_high;
                flags.zero       = (daa_val == '0);
                flags.parity     = ~^daa_val;
                flags.half_carry = 1'b0;
            end
            afl_pkg::ACT_SCF:
            begin
                flags.subtract   = 1'b0;
                flags.half_carry = 1'b0;
                flags.carry      = 1'b1;
            end
            afl_pkg::ACT_CCF:
            begin
                flags.subtract   = 1'b0;
                flags.half_carry = 1'b0;
                flags.carry      = ~cin;
            end
            default:
            begin
                r = '0;
            end
        endcase
        res.result        = r;
        res.flags         = flags;
        res.bad_bit_index = bad;
    end

endmodule

// ----- hw/rtl/alu_with_flags_top.sv -----
// top level: input register, alu datapath, flag register and result register
// path: an accepted input item waits in the input register, passes the alu and is held in the result register
// throughput: one item per cycle while the result side takes results; the alu and flag update finish in one pass
// stalls come only from the result side, the input register holds one item
// reset: flags clear to zero and both registers are emptied
module alu_with_flags_top
(
    input logic      clk,
    input logic      rst_n,
    afl_in_if.sink   req,
    afl_out_if.source rsp
);

    logic              in_valid_reg;
    afl_pkg::item_t    in_item_reg;
    logic              out_valid_reg;
    afl_pkg::result_t  out_reg;
    afl_pkg::flags_t   flag_reg;
    afl_pkg::result_t  core_res;
    logic              advance;
    logic              in_take;

    // pipeline control
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign in_take   = req.valid && req.ready;

    // datapath
    afl_alu u_alu
    (
        .item     (in_item_reg),
        .flags_in (flag_reg),
        .res      (core_res)
    );

    // valid bits and flag register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flag_reg      <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                flag_reg      <= core_res.flags;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= '{action:        req.action,
                             left_operand:  req.left_operand,
                             right_operand: req.right_operand,
                             width_select:  req.width_select,
                             bit_index:     req.bit_index};
        end
        if (advance)
        begin
            out_reg <= core_res;
        end
    end

    // result port
    assign rsp.valid           = out_valid_reg;
    assign rsp.result          = out_reg.result;
    assign rsp.zero_flag       = out_reg.flags.zero;
    assign rsp.subtract_flag   = out_reg.flags.subtract;
    assign rsp.half_carry_flag = out_reg.flags.half_carry;
    assign rsp.carry_flag      = out_reg.flags.carry;
    assign rsp.parity_flag     = out_reg.flags.parity;
    assign rsp.sign_flag       = out_reg.flags.sign;
    assign rsp.bad_bit_index   = out_reg.bad_bit_index;

    // flags shown with an item match the flag register
    a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_reg.flags == flag_reg))
        else $error("result flags differ from flag register");

    // flag register only moves when an item passes the alu
    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(flag_reg))
        else $error("flag register changed without an item");

    // a bad bit index leaves the flags alone
    a_bad_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && core_res.bad_bit_index) |=> (flag_reg == $past(flag_reg)))
        else $error("flags changed on bad bit index");

    // input stalls only when the result side holds back
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !req.ready) |-> (out_valid_reg && !rsp.ready))
        else $error("input stalled without output back-pressure");

endmodule

// ----- test/alu_with_flags_top_test.sv -----
`timescale 1ns / 1ps
// testbench for the flag-setting alu: directed and random items against a flag-tracking predictor
module alu_with_flags_top_test;
    import afl_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_ITEMS   = 420;
    localparam int MAX_REPORTS    = 10;

    // codes the package does not name
    localparam logic [1:0] WS_8        = 2'd2;
    localparam logic [1:0] WS_BYTE_ALT = 2'd3;
    localparam logic [4:0] ACT_SPARE   = 5'h1F;

    typedef struct {
        item_t op;
        bit    drain_first;
    } pending_t;

    logic clk;
    logic rst_n;

    afl_in_if  req ();
    afl_out_if rsp ();

    alu_with_flags_top DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    pending_t pending_q[$];
    result_t  alu_results_q[$];
    flags_t   alu_flags = '0;
    item_t    driven_item;
    int       mismatches = 0;
    int       idle_cycles = 0;
    int       send_gap = 0;
    int       send_calm = 0;
    int       recv_gap = 0;
    int       recv_calm = 0;

    // mostly short gaps, a few long ones, now and then a stretch with none
    function automatic int pick_gap(inout int calm);
        int roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // computes the result of one item and moves the flag register on
    function automatic result_t alu_predict(input item_t op);
        logic [31:0] m, hm, a, b, r;
        logic [4:0]  top;
        logic [32:0] wide;
        logic        cin, c, msb, lsb, borrow, bad;
        logic [7:0]  al, adj;
        flags_t      f;
        result_t     res;
        f = alu_flags;
        if (op.width_select == WS_32)
        begin
            m = MASK_32;
            hm = HALF_MASK_32;
            top = TOP_32;
        end
        else if (op.width_select == WS_16)
        begin
            m = MASK_16;
            hm = HALF_MASK_16;
            top = TOP_16;
        end
        else
        begin
            m = MASK_8;
            hm = HALF_MASK_8;
            top = TOP_8;
        end
        a = op.left_operand & m;
        b = op.right_operand & m;
        cin = f.carry;
        msb = b[top];
        lsb = b[0];
        r = '0;
        bad = 1'b0;
        case (op.action)
            ACT_ADD, ACT_ADC:
            begin
                c = (op.action == ACT_ADC) ? cin : 1'b0;
                wide = {1'b0, a} + {1'b0, b} + 33'(c);
                r = wide[31:0] & m;
                f.subtract = 1'b0;
                f.sign = 1'b0;
                f.half_carry = ({1'b0, a & hm} + {1'b0, b & hm} + 33'(c)) > {1'b0, hm};
                f.carry = wide > {1'b0, m};
                f.zero = (r == '0);
                f.parity = ~^r;
            end
            ACT_SUB, ACT_SBC, ACT_CMP:
            begin
                c = (op.action == ACT_SBC) ? cin : 1'b0;
                borrow = {1'b0, a} < ({1'b0, b} + 33'(c));
                r = (a - b - 32'(c)) & m;
                f.subtract = 1'b1;
                f.carry = borrow;
                f.sign = borrow;
                f.half_carry = {1'b0, a & hm} < ({1'b0, b & hm} + 33'(c));
                f.zero = (r == '0);
                if (op.action == ACT_CMP)
                    r = a;
                else
                    f.parity = ~^r;
            end
            ACT_AND, ACT_OR, ACT_XOR:
            begin
                if (op.action == ACT_AND)
                    r = a & b;
                else if (op.action == ACT_OR)
                    r = a | b;
                else
                    r = a ^ b;
                f.subtract = 1'b0;
                f.half_carry = (op.action == ACT_AND);
                f.carry = 1'b0;
                f.sign = 1'b0;
                f.zero = (r == '0);
                f.parity = ~^r;
            end
            ACT_NOT:
            begin
                r = ~b & m;
                f.subtract = 1'b1;
                f.half_carry = 1'b1;
            end
            ACT_INC, ACT_DEC:
            begin
                r = (op.action == ACT_INC) ? ((b + 32'd1) & m) : ((b - 32'd1) & m);
                f.zero = (r == '0);
                f.parity = ~^r;
                if (op.width_select != WS_32)
                    f.half_carry = (op.action == ACT_INC) ? ((r & hm) == '0) : ((r & hm) == hm);
                f.subtract = (op.action == ACT_DEC);
            end
            ACT_SLA, ACT_SRA, ACT_SRL, ACT_RL, ACT_RLC, ACT_RR, ACT_RRC:
            begin
                case (op.action)
                    ACT_SLA: r = b << 1;
                    ACT_SRA: r = (b >> 1) | (32'(msb) << top);
                    ACT_SRL: r = b >> 1;
                    ACT_RL:  r = (b << 1) | 32'(cin);
                    ACT_RLC: r = (b << 1) | 32'(msb);
                    ACT_RR:  r = (b >> 1) | (32'(cin) << top);
                    default: r = (b >> 1) | (32'(lsb) << top);
                endcase
                r = r & m;
                f.subtract = 1'b0;
                f.half_carry = 1'b0;
                if (op.action == ACT_SLA || op.action == ACT_RL || op.action == ACT_RLC)
                    f.carry = msb;
                else
                    f.carry = lsb;
                f.zero = (r == '0);
                if (op.action != ACT_RLC && op.action != ACT_RRC)
                    f.parity = ~^r;
            end
            ACT_BIT, ACT_TOG, ACT_SET, ACT_RES:
            begin
                if (op.bit_index > {3'b000, top})
                begin
                    bad = 1'b1;
                    r = (op.action == ACT_BIT) ? a : b;
                end
                else if (op.action == ACT_BIT)
                begin
                    r = a;
                    f.zero = ~b[op.bit_index[4:0]];
                    f.subtract = 1'b0;
                    f.half_carry = 1'b1;
                end
                else if (op.action == ACT_TOG)
                    r = (b ^ (32'd1 << op.bit_index[4:0])) & m;
                else if (op.action == ACT_SET)
                    r = (b | (32'd1 << op.bit_index[4:0])) & m;
                else
                    r = (b & ~(32'd1 << op.bit_index[4:0])) & m;
            end
            ACT_DAA:
            begin
                al = op.left_operand[7:0];
                adj = '0;
                if (f.half_carry || al[3:0] > DAA_DIGIT_MAX)
                    adj = adj + DAA_LOW_ADJ;
                if (f.carry || al[7:4] > DAA_DIGIT_MAX)
                begin
                    adj = adj + DAA_HIGH_ADJ;
                    f.carry = 1'b1;
                end
                else
                    f.carry = 1'b0;
                r = {24'd0, f.subtract ? (al - adj) : (al + adj)};
                f.zero = (r == '0);
                f.parity = ~^r;
                f.half_carry = 1'b0;
            end
            ACT_SCF, ACT_CCF:
            begin
                f.subtract = 1'b0;
                f.half_carry = 1'b0;
                f.carry = (op.action == ACT_SCF) ? 1'b1 : ~cin;
            end
            default:
            begin
            end
        endcase
        alu_flags = f;
        res.result = r;
        res.flags = f;
        res.bad_bit_index = bad;
        return res;
    endfunction

    task automatic queue_item(input logic [4:0] act, input logic [31:0] lhs,
                              input logic [31:0] rhs, input logic [1:0] ws,
                              input logic [7:0] idx, input bit drain);
        pending_t p;
        p.op.action = act;
        p.op.left_operand = lhs;
        p.op.right_operand = rhs;
        p.op.width_select = ws;
        p.op.bit_index = idx;
        p.drain_first = drain;
        pending_q.push_back(p);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            3: return $urandom_range(0, 20);
            4: return (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
            default: return $urandom;
        endcase
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver: presents pending items and predicts each one as it is accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                alu_results_q.push_back(alu_predict(driven_item));
            if (!req.valid || req.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req.valid <= 1'b0;
                end
                else if (pending_q.size() != 0 &&
                         !(pending_q[0].drain_first && alu_results_q.size() != 0))
                begin
                    driven_item = pending_q[0].op;
                    pending_q.pop_front();
                    req.valid <= 1'b1;
                    req.action <= driven_item.action;
                    req.left_operand <= driven_item.left_operand;
                    req.right_operand <= driven_item.right_operand;
                    req.width_select <= driven_item.width_select;
                    req.bit_index <= driven_item.bit_index;
                    send_gap = pick_gap(send_calm);
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // result side stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                recv_gap = pick_gap(recv_calm);
            if (recv_gap > 0)
            begin
                recv_gap--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // monitor: each result item against the oldest prediction
    always @(posedge clk)
    begin
        result_t want, got;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got.result = rsp.result;
            got.flags.zero = rsp.zero_flag;
            got.flags.subtract = rsp.subtract_flag;
            got.flags.half_carry = rsp.half_carry_flag;
            got.flags.carry = rsp.carry_flag;
            got.flags.parity = rsp.parity_flag;
            got.flags.sign = rsp.sign_flag;
            got.bad_bit_index = rsp.bad_bit_index;
            if (alu_results_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result item %h flags %b bad %b",
                             got.result, got.flags, got.bad_bit_index);
            end
            else
            begin
                want = alu_results_q.pop_front();
                if (got.result !== want.result || got.flags.zero !== want.flags.zero ||
                    got.flags.subtract !== want.flags.subtract ||
                    got.flags.half_carry !== want.flags.half_carry ||
                    got.flags.carry !== want.flags.carry ||
                    got.flags.parity !== want.flags.parity ||
                    got.flags.sign !== want.flags.sign ||
                    got.bad_bit_index !== want.bad_bit_index)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: want %h spchnz %b bad %b, got %h spchnz %b bad %b",
                                 want.result, want.flags, want.bad_bit_index,
                                 got.result, got.flags, got.bad_bit_index);
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        int          added;
        logic [4:0]  act;
        logic [1:0]  ws;
        logic [7:0]  idx, x, y;
        logic [31:0] top_bit;
        bit          drain, drain_done;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.action = ACT_ADD;
        req.left_operand = '0;
        req.right_operand = '0;
        req.width_select = WS_32;
        req.bit_index = '0;
        rsp.ready = 1'b0;

        // directed: extremes, every operation and the odd cases
        queue_item(ACT_ADD, '1, '1, WS_32, 8'd0, 1'b0);
        queue_item(ACT_ADC, 32'h0000_7FFF, 32'h0000_8000, WS_16, 8'd0, 1'b0);
        queue_item(ACT_SUB, 32'h0000_0000, 32'h0000_0001, WS_8, 8'd0, 1'b0);
        queue_item(ACT_SBC, 32'h0000_0010, 32'h0000_000F, WS_8, 8'd0, 1'b0);
        queue_item(ACT_CMP, 32'h1234_5678, 32'h1234_5679, WS_32, 8'd0, 1'b0);
        queue_item(ACT_AND, 32'hF0F0_F0F0, 32'hFF00_FF00, WS_32, 8'd0, 1'b0);
        queue_item(ACT_OR, 32'hFFFF_0000, 32'hFFFF_0000, WS_16, 8'd0, 1'b0);
        queue_item(ACT_XOR, '1, 32'h5555_5555, WS_BYTE_ALT, 8'd0, 1'b0);
        queue_item(ACT_NOT, '0, 32'h0000_00A5, WS_8, 8'd0, 1'b0);
        queue_item(ACT_INC, '0, 32'h0000_0FFF, WS_16, 8'd0, 1'b0);
        queue_item(ACT_INC, '0, '1, WS_32, 8'd0, 1'b0);
        queue_item(ACT_DEC, '0, '0, WS_8, 8'd0, 1'b0);
        queue_item(ACT_SLA, '0, 32'h8000_0001, WS_32, 8'd0, 1'b0);
        queue_item(ACT_SRA, '0, 32'h0000_8002, WS_16, 8'd0, 1'b0);
        queue_item(ACT_SRL, '0, 32'h0000_0081, WS_8, 8'd0, 1'b0);
        queue_item(ACT_RL, '0, 32'h0000_0080, WS_8, 8'd0, 1'b0);
        queue_item(ACT_RLC, '0, 32'h8000_0000, WS_32, 8'd0, 1'b0);
        queue_item(ACT_RR, '0, 32'h0000_0001, WS_16, 8'd0, 1'b0);
        queue_item(ACT_RRC, '0, 32'h0000_0001, WS_8, 8'd0, 1'b0);
        queue_item(ACT_BIT, 32'hCAFE_F00D, 32'h8000_0000, WS_32, 8'd31, 1'b0);
        queue_item(ACT_BIT, 32'h0000_0155, 32'h0000_0155, WS_8, 8'd8, 1'b0);
        queue_item(ACT_TOG, '0, 32'h0000_FFFF, WS_16, 8'd15, 1'b0);
        queue_item(ACT_SET, '0, 32'h0001_0000, WS_32, 8'd255, 1'b0);
        queue_item(ACT_RES, '0, '1, WS_8, 8'd0, 1'b0);
        // bcd add then adjust, bcd subtract then adjust
        queue_item(ACT_ADD, 32'h0000_0015, 32'h0000_0027, WS_8, 8'd0, 1'b0);
        queue_item(ACT_DAA, 32'h0000_003C, '0, WS_8, 8'd0, 1'b0);
        queue_item(ACT_SUB, 32'h0000_0042, 32'h0000_0019, WS_8, 8'd0, 1'b0);
        queue_item(ACT_DAA, 32'h0000_0029, '0, WS_32, 8'd0, 1'b0);
        queue_item(ACT_SCF, '0, '0, WS_32, 8'd0, 1'b0);
        queue_item(ACT_CCF, '0, '0, WS_32, 8'd0, 1'b0);
        queue_item(ACT_SPARE, '1, '1, WS_8, 8'hFF, 1'b0);

        // random part, with bcd sequences and one full drain half way
        added = 0;
        drain_done = 1'b0;
        while (added < RANDOM_ITEMS)
        begin
            // the first item of the second half waits for every result
            drain = !drain_done && added >= RANDOM_ITEMS / 2;
            if (drain)
                drain_done = 1'b1;
            if ($urandom_range(0, 99) < 12)
            begin
                x = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
                y = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
                ws = $urandom_range(0, 1) ? WS_8 : WS_BYTE_ALT;
                if ($urandom_range(0, 1))
                begin
                    queue_item(ACT_ADD, {24'd0, x}, {24'd0, y}, ws, 8'($urandom), drain);
                    idx = x + y;
                end
                else
                begin
                    queue_item(ACT_SUB, {24'd0, x}, {24'd0, y}, ws, 8'($urandom), drain);
                    idx = x - y;
                end
                queue_item(ACT_DAA, {24'($urandom), idx}, $urandom, 2'($urandom_range(0, 3)),
                           8'($urandom), 1'b0);
                added += 2;
            end
            else
            begin
                if ($urandom_range(0, 99) < 4)
                    act = 5'($urandom_range(ACT_CCF + 5'd1, ACT_SPARE));
                else
                    act = 5'($urandom_range(ACT_ADD, ACT_CCF));
                ws = 2'($urandom_range(0, 3));
                top_bit = (ws == WS_32) ? 32'(TOP_32)
                        : ((ws == WS_16) ? 32'(TOP_16) : 32'(TOP_8));
                if ($urandom_range(0, 99) < 70)
                    idx = 8'($urandom_range(0, top_bit + 2));
                else
                    idx = 8'($urandom);
                queue_item(act, pick_operand(), pick_operand(), ws, idx, drain);
                added++;
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // wait for everything to be sent and answered, then let the bench settle
        while (pending_q.size() != 0 || req.valid || alu_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && alu_results_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
